// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lrf_pkg.sv =====
// ----------------------------------------------------------------------------
// lrf_pkg
// Types and constants of the lidar revolution framer.
// ----------------------------------------------------------------------------
package lrf_pkg;

   localparam int ANGLE_W  = 15;
   localparam int COUNT_W  = 13;
   localparam int SPAN_W   = 27;
   localparam int CSR_W    = 27;
   localparam int CSR_AW   = 2;

   // one full turn in 1/64 degree
   localparam logic [ANGLE_W-1:0] TURN_UNITS = 15'd23040;

   localparam int MAX_NODES_DEFAULT = 4096;

   localparam logic [COUNT_W-1:0] MIN_POINTS_RST    = 13'd50;
   localparam logic [SPAN_W-1:0]  MIN_SPAN_RST      = 27'd19200;
   localparam logic [ANGLE_W-1:0] ROLLOVER_HIGH_RST = 15'd20160;
   localparam logic [ANGLE_W-1:0] ROLLOVER_LOW_RST  = 15'd2880;

   typedef enum logic [CSR_AW-1:0] {
      CSR_MIN_POINTS    = 2'd0,
      CSR_MIN_SPAN      = 2'd1,
      CSR_ROLLOVER_HIGH = 2'd2,
      CSR_ROLLOVER_LOW  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] min_points;
      logic [SPAN_W-1:0]  min_span;
      logic [ANGLE_W-1:0] rollover_high;
      logic [ANGLE_W-1:0] rollover_low;
   } cfg_type;

   typedef struct packed {
      logic               ring_flag;
      logic               packet_first;
      logic [ANGLE_W-1:0] angle;
   } node_type;

   typedef struct packed {
      logic               by_rollover;
      logic               complete;
      logic [SPAN_W-1:0]  swept_span;
      logic [COUNT_W-1:0] node_count;
   } result_type;

endpackage

// ===== rtl/lidar_revolution_framer.sv =====
// ----------------------------------------------------------------------------
// lidar_revolution_framer
// Groups lidar nodes into revolutions and reports one verdict per revolution.
// ----------------------------------------------------------------------------
// Takes one node per clock and, with no stall on the result side, keeps that
// rate indefinitely. A node passes an input register, then combinational
// arithmetic (a modulo-turn subtract, a saturating span add and the threshold
// compares) that updates the revolution state and loads the result register:
// a verdict is offered in the cycle after the core takes the node that closes
// the revolution, and can transfer at the following edge at the earliest.
// A boundary is the first node of a packet that carries the ring flag or
// whose angle rolls over from above rollover_high to below rollover_low;
// nodes past MAX_NODES in a revolution are dropped.
`include "assert_macros.svh"

module lidar_revolution_framer #(
   parameter int MAX_NODES = lrf_pkg::MAX_NODES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_we,
   input  logic [lrf_pkg::CSR_AW-1:0] csr_addr,
   input  logic [lrf_pkg::CSR_W-1:0]  csr_wdata,
   // nodes
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,  // [14:0] angle, [15] zero
   input  logic [1:0]                 req_tuser,  // [0] packet_first, [1] ring_flag
   // verdicts
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [39:0]                rsp_tdata,  // [12:0] node_count, [39:13] swept_span
   output logic [1:0]                 rsp_tuser   // [0] complete, [1] by_rollover
);

   localparam int CNT_W = $clog2(MAX_NODES + 1);

   lrf_pkg::cfg_type    cfg;
   lrf_pkg::node_type   req_node, stage_node;
   lrf_pkg::result_type result;
   logic                stage_valid, stage_ready;
   logic                emit;
   logic [CNT_W-1:0]    held_count;

   assign req_node.angle        = req_tdata[lrf_pkg::ANGLE_W-1:0];
   assign req_node.packet_first = req_tuser[0];
   assign req_node.ring_flag    = req_tuser[1];

   lrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lrf_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_node   (req_node),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_node  (stage_node)
   );

   lrf_core #(
      .MAX_NODES (MAX_NODES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .node_valid   (stage_valid),
      .node_ready   (stage_ready),
      .node         (stage_node),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result),
      .emit         (emit),
      .held_count   (held_count)
   );

   assign rsp_tdata = {result.swept_span, result.node_count};
   assign rsp_tuser = {result.by_rollover, result.complete};

   // count never runs past the cap
   `ASSERT_ALWAYS(a_count_capped, held_count <= CNT_W'(MAX_NODES), "held count above cap")
   // a closed revolution restarts with exactly the boundary node
   `ASSERT_NEXT(a_restart_one, emit, held_count == CNT_W'(1), "restart count not one")
   // input side stalls only when both registers are full and the output is blocked
   `ASSERT_ALWAYS(a_stall_cause, req_tready || (stage_valid && rsp_tvalid && !rsp_tready),
      "input stalled without cause")

endmodule

// ===== rtl/lrf_csr.sv =====
// ----------------------------------------------------------------------------
// lrf_csr
// Configuration registers of the revolution framer.
// ----------------------------------------------------------------------------
module lrf_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [lrf_pkg::CSR_AW-1:0] csr_addr,
   input  logic [lrf_pkg::CSR_W-1:0]  csr_wdata,
   output lrf_pkg::cfg_type           cfg
);

   lrf_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (lrf_pkg::csr_index_type'(csr_addr))
            lrf_pkg::CSR_MIN_POINTS:
               cfg_in.min_points = csr_wdata[lrf_pkg::COUNT_W-1:0];
            lrf_pkg::CSR_MIN_SPAN:
               cfg_in.min_span = csr_wdata[lrf_pkg::SPAN_W-1:0];
            lrf_pkg::CSR_ROLLOVER_HIGH:
               cfg_in.rollover_high = csr_wdata[lrf_pkg::ANGLE_W-1:0];
            lrf_pkg::CSR_ROLLOVER_LOW:
               cfg_in.rollover_low = csr_wdata[lrf_pkg::ANGLE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_points    <= lrf_pkg::MIN_POINTS_RST;
         cfg_ff.min_span      <= lrf_pkg::MIN_SPAN_RST;
         cfg_ff.rollover_high <= lrf_pkg::ROLLOVER_HIGH_RST;
         cfg_ff.rollover_low  <= lrf_pkg::ROLLOVER_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/lrf_in_stage.sv =====
// ----------------------------------------------------------------------------
// lrf_in_stage
// Input register: captures one node per transfer, frees as the core takes it.
// ----------------------------------------------------------------------------
module lrf_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lrf_pkg::node_type in_node,
   output logic              out_valid,
   input  logic              out_ready,
   output lrf_pkg::node_type out_node
);

   logic              valid_ff, valid_in;
   lrf_pkg::node_type node_ff, node_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      node_in  = node_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            node_in = in_node;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign out_valid = valid_ff;
   assign out_node  = node_ff;

endmodule

// ===== rtl/lrf_core.sv =====
// ----------------------------------------------------------------------------
// lrf_core
// Revolution state (last angle, count, span), boundary test and result register.
// ----------------------------------------------------------------------------
module lrf_core #(
   parameter int MAX_NODES = lrf_pkg::MAX_NODES_DEFAULT,
   localparam int CNT_W = $clog2(MAX_NODES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lrf_pkg::cfg_type            cfg,
   input  logic                        node_valid,
   output logic                        node_ready,
   input  lrf_pkg::node_type           node,
   output logic                        result_valid,
   input  logic                        result_ready,
   output lrf_pkg::result_type         result,
   output logic                        emit,
   output logic [CNT_W-1:0]            held_count
);

   localparam int CMP_W = (CNT_W > lrf_pkg::COUNT_W) ? CNT_W : lrf_pkg::COUNT_W;
   localparam int AW    = lrf_pkg::ANGLE_W;
   localparam int SW    = lrf_pkg::SPAN_W;

   // bring a raw 15-bit angle into 0..TURN_UNITS-1 (value is below two turns)
   function automatic logic [AW-1:0] wrap_angle(input logic [AW-1:0] a);
      return (a >= lrf_pkg::TURN_UNITS) ? a - lrf_pkg::TURN_UNITS : a;
   endfunction

   logic [AW-1:0]    prev_ff, prev_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SW-1:0]    span_ff, span_in;
   logic             rvalid_ff, rvalid_in;
   lrf_pkg::result_type result_ff, result_in;

   logic             take;
   logic             boundary;
   logic             rolled;
   logic [CNT_W-1:0] count_base;
   logic [SW-1:0]    span_base;
   logic [AW-1:0]    a_wrap, b_wrap, delta;
   logic [SW:0]      span_sum;
   logic [CMP_W-1:0] count_ext;

   assign node_ready = !rvalid_ff || result_ready;
   assign take       = node_valid && node_ready;

   assign rolled   = !node.ring_flag && (prev_ff > cfg.rollover_high)
                     && (node.angle < cfg.rollover_low);
   assign boundary = node.packet_first && (count_ff != '0) && (node.ring_flag || rolled);

   assign count_base = boundary ? '0 : count_ff;
   assign span_base  = boundary ? '0 : span_ff;
   assign count_ext  = CMP_W'(count_ff);

   // forward delta modulo one turn
   assign a_wrap = wrap_angle(node.angle);
   assign b_wrap = wrap_angle(prev_ff);
   assign delta  = (a_wrap >= b_wrap) ? a_wrap - b_wrap
                                      : a_wrap + lrf_pkg::TURN_UNITS - b_wrap;
   assign span_sum = {1'b0, span_base} + (SW+1)'(delta);

   always_comb begin
      prev_in  = prev_ff;
      count_in = count_ff;
      span_in  = span_ff;
      if (take) begin
         count_in = count_base;
         span_in  = span_base;
         if (count_base < CNT_W'(MAX_NODES)) begin
            if (count_base != '0) begin
               span_in = span_sum[SW] ? {SW{1'b1}} : span_sum[SW-1:0];
            end
            prev_in  = node.angle;
            count_in = count_base + CNT_W'(1);
         end
      end
   end

   always_comb begin
      rvalid_in = rvalid_ff && !result_ready;
      result_in = result_ff;
      if (take && boundary) begin
         rvalid_in             = 1'b1;
         result_in.node_count  = count_ext[lrf_pkg::COUNT_W-1:0];
         result_in.swept_span  = span_ff;
         result_in.complete    = (count_ext >= CMP_W'(cfg.min_points))
                                 && (span_ff >= cfg.min_span);
         result_in.by_rollover = !node.ring_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         count_ff  <= '0;
         span_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         prev_ff   <= prev_in;
         count_ff  <= count_in;
         span_ff   <= span_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result_valid = rvalid_ff;
   assign result       = result_ff;
   assign emit         = take && boundary;
   assign held_count   = count_ff;

endmodule
